// ----- rtl/hcd_pkg.sv -----
// Shared types, constants and helpers of the chunked body deframer.
package hcd_pkg;

	localparam int SIZE_BITS_DEF = 32;
	localparam int CLEN_BITS     = 32;
	localparam int ADDR_BITS     = 3;
	localparam int DATA_BITS     = 32;
	localparam int HEX_BITS      = 4;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	localparam logic REG_CHUNKED_MODE = 1'b0;
	localparam logic REG_BODY_LEN     = 1'b1;

	localparam logic [2:0] KIND_DIGIT   = 3'd0;
	localparam logic [2:0] KIND_FRAME   = 3'd1;
	localparam logic [2:0] KIND_PAYLOAD = 3'd2;
	localparam logic [2:0] KIND_CRLF    = 3'd3;
	localparam logic [2:0] KIND_TRAILER = 3'd4;
	localparam logic [2:0] KIND_PAST    = 3'd5;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
	localparam logic [2:0] ERR_OVERFLOW = 3'd2;
	localparam logic [2:0] ERR_NO_CR    = 3'd3;
	localparam logic [2:0] ERR_NO_LF    = 3'd4;

	typedef enum logic [12:0] {
		PH_LEN      = 13'b0000000000001,
		PH_SIZE     = 13'b0000000000010,
		PH_EXT      = 13'b0000000000100,
		PH_SIZE_LF  = 13'b0000000001000,
		PH_PAYLOAD  = 13'b0000000010000,
		PH_CHUNK_CR = 13'b0000000100000,
		PH_CHUNK_LF = 13'b0000001000000,
		PH_T_SEARCH = 13'b0000010000000,
		PH_T_LF     = 13'b0000100000000,
		PH_T_CR2    = 13'b0001000000000,
		PH_T_LF2    = 13'b0010000000000,
		PH_DONE     = 13'b0100000000000,
		PH_HALT     = 13'b1000000000000
	} phase_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic [2:0] byte_kind;
		logic       body_done;
		logic [2:0] error_code;
	} result_t;

	typedef struct packed {
		logic                 chunked_mode;
		logic [CLEN_BITS-1:0] body_len;
	} cfg_t;

	typedef struct packed {
		logic                valid;
		logic [HEX_BITS-1:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.valid = 1'b1;
		h.value = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = HEX_BITS'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.value = HEX_BITS'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.value = HEX_BITS'(c - 8'h37);
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

endpackage

// ----- rtl/hcd_if.sv -----
// Valid/ready stream interfaces for body bytes in and classified bytes out.
interface hcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       body_start;

	modport source (output valid, data_byte, body_start, input ready);
	modport sink (input valid, data_byte, body_start, output ready);
endinterface

interface hcd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic [2:0] byte_kind;
	logic       body_done;
	logic [2:0] error_code;

	modport source (output valid, byte_out, byte_kind, body_done, error_code, input ready);
	modport sink (input valid, byte_out, byte_kind, body_done, error_code, output ready);
endinterface

// ----- rtl/hcd_regs.sv -----
// APB configuration registers: chunked mode select and content length.
module hcd_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hcd_pkg::ADDR_BITS-1:0] paddr,
	input  logic [hcd_pkg::DATA_BITS-1:0] pwdata,
	output logic [hcd_pkg::DATA_BITS-1:0] prdata,
	output logic                         pready,
	output hcd_pkg::cfg_t                cfg
);
	import hcd_pkg::*;

	logic                 chunked_mode_q;
	logic [CLEN_BITS-1:0] body_len_q;
	logic                 wr_en;
	logic                 reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_mode_q <= 1'b0;
			body_len_q     <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_CHUNKED_MODE: chunked_mode_q <= pwdata[0];
				REG_BODY_LEN:     body_len_q     <= pwdata[CLEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_CHUNKED_MODE: prdata = {{(DATA_BITS-1){1'b0}}, chunked_mode_q};
			REG_BODY_LEN:     prdata = DATA_BITS'(body_len_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.chunked_mode = chunked_mode_q;
	assign cfg.body_len     = body_len_q;
endmodule

// ----- rtl/hcd_parser.sv -----
// Framing state and the per-byte classification step.
module hcd_parser #(
	parameter int SIZE_BITS = hcd_pkg::SIZE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       data_byte,
	input  logic             body_start,
	input  hcd_pkg::cfg_t    cfg,
	output hcd_pkg::result_t result
);
	import hcd_pkg::*;

	localparam int CNT_BITS = (SIZE_BITS > CLEN_BITS) ? SIZE_BITS : CLEN_BITS;

	phase_t               phase_q, phase_d, ph;
	logic [CNT_BITS-1:0]  remain_q, remain_d, remain_dec;
	logic [SIZE_BITS-1:0] acc_q, acc_d;
	logic                 has_digit_q, has_digit_d;
	logic                 last_chunk_q, last_chunk_d;
	hex_t                 hex;

	assign hex = hex_decode(data_byte);

	always_comb begin
		ph           = phase_q;
		remain_d     = remain_q;
		acc_d        = acc_q;
		has_digit_d  = has_digit_q;
		last_chunk_d = last_chunk_q;
		if (body_start) begin
			acc_d        = '0;
			has_digit_d  = 1'b0;
			last_chunk_d = 1'b0;
			if (cfg.chunked_mode) begin
				ph       = PH_SIZE;
				remain_d = '0;
			end else begin
				ph       = PH_LEN;
				remain_d = CNT_BITS'(cfg.body_len);
			end
		end
		phase_d    = ph;
		remain_dec = remain_d - CNT_BITS'(1);

		result.byte_out   = data_byte;
		result.byte_kind  = KIND_PAST;
		result.body_done  = 1'b0;
		result.error_code = ERR_NONE;

		unique case (ph)
			PH_LEN: begin
				if (remain_d != '0) begin
					result.byte_kind = KIND_PAYLOAD;
					remain_d = remain_dec;
					if (remain_dec == '0) begin
						result.body_done = 1'b1;
						phase_d = PH_DONE;
					end
				end
			end
			PH_SIZE: begin
				result.byte_kind = KIND_DIGIT;
				if (hex.valid) begin
					if (acc_d[SIZE_BITS-1 -: HEX_BITS] != '0) begin
						result.error_code = ERR_OVERFLOW;
						phase_d = PH_HALT;
					end else begin
						acc_d       = {acc_d[SIZE_BITS-HEX_BITS-1:0], hex.value};
						has_digit_d = 1'b1;
					end
				end else if ((data_byte == CH_SEMI || data_byte == CH_CR) && has_digit_d) begin
					result.byte_kind = KIND_FRAME;
					phase_d = (data_byte == CH_CR) ? PH_SIZE_LF : PH_EXT;
				end else begin
					result.error_code = ERR_BAD_CHAR;
					phase_d = PH_HALT;
				end
			end
			PH_EXT: begin
				result.byte_kind = KIND_FRAME;
				if (data_byte == CH_CR) phase_d = PH_SIZE_LF;
			end
			PH_SIZE_LF: begin
				result.byte_kind = KIND_FRAME;
				if (data_byte == CH_LF) begin
					if (acc_d == '0) begin
						last_chunk_d = 1'b1;
						phase_d = PH_CHUNK_CR;
					end else begin
						remain_d = CNT_BITS'(acc_d);
						acc_d    = '0;
						phase_d  = PH_PAYLOAD;
					end
				end else if (data_byte != CH_CR) begin
					phase_d = PH_EXT;
				end
			end
			PH_PAYLOAD: begin
				result.byte_kind = KIND_PAYLOAD;
				if (remain_d != '0) remain_d = remain_dec;
				if (remain_d == '0) phase_d = PH_CHUNK_CR;
			end
			PH_CHUNK_CR: begin
				if (data_byte == CH_CR) begin
					result.byte_kind = KIND_CRLF;
					phase_d = PH_CHUNK_LF;
				end else if (last_chunk_d) begin
					result.byte_kind = KIND_TRAILER;
					phase_d = PH_T_SEARCH;
				end else begin
					result.byte_kind  = KIND_CRLF;
					result.error_code = ERR_NO_CR;
					phase_d = PH_HALT;
				end
			end
			PH_CHUNK_LF: begin
				result.byte_kind = KIND_CRLF;
				if (data_byte != CH_LF) begin
					result.error_code = ERR_NO_LF;
					phase_d = PH_HALT;
				end else if (last_chunk_d) begin
					result.body_done = 1'b1;
					phase_d = PH_DONE;
				end else begin
					acc_d       = '0;
					has_digit_d = 1'b0;
					phase_d     = PH_SIZE;
				end
			end
			PH_T_SEARCH: begin
				result.byte_kind = KIND_TRAILER;
				if (data_byte == CH_CR) phase_d = PH_T_LF;
			end
			PH_T_LF: begin
				result.byte_kind = KIND_TRAILER;
				if (data_byte == CH_LF) phase_d = PH_T_CR2;
				else if (data_byte != CH_CR) phase_d = PH_T_SEARCH;
			end
			PH_T_CR2: begin
				result.byte_kind = KIND_TRAILER;
				phase_d = (data_byte == CH_CR) ? PH_T_LF2 : PH_T_SEARCH;
			end
			PH_T_LF2: begin
				result.byte_kind = KIND_TRAILER;
				if (data_byte == CH_LF) begin
					result.body_done = 1'b1;
					phase_d = PH_DONE;
				end else begin
					phase_d = (data_byte == CH_CR) ? PH_T_LF : PH_T_SEARCH;
				end
			end
			PH_DONE, PH_HALT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LEN;
			remain_q     <= '0;
			acc_q        <= '0;
			has_digit_q  <= 1'b0;
			last_chunk_q <= 1'b0;
		end else if (advance) begin
			phase_q      <= phase_d;
			remain_q     <= remain_d;
			acc_q        <= acc_d;
			has_digit_q  <= has_digit_d;
			last_chunk_q <= last_chunk_d;
		end
	end
endmodule

// ----- rtl/http_chunked_body_deframer.sv -----
// Top level of the HTTP chunked / fixed-length message body deframer.
//
// body_in carries raw body bytes (data_byte) with body_start marking the
// first byte of a new body; body_out returns one beat per input beat with
// the byte, its kind, body_done and an error code. Registers are written
// through the APB port: chunked_mode at 0x0, body length at 0x4; they
// are sampled on the beat that carries body_start.
// An accepted input beat is held in the input register, then the parse
// step loads the output register. Throughput is one byte per cycle while
// the receiver does not stall, set by the state update of the parser.
// Reset clears the registers and the framing state (length mode, nothing
// remaining) and empties both stages, so bytes before body_start come out
// as past end. When the receiver stalls, the output register holds its
// beat, the input register holds one more, and body_in.ready then drops.
module http_chunked_body_deframer #(
	parameter int SIZE_BITS = hcd_pkg::SIZE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	hcd_in_if.sink                        body_in,
	hcd_out_if.source                     body_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hcd_pkg::ADDR_BITS-1:0] paddr,
	input  logic [hcd_pkg::DATA_BITS-1:0] pwdata,
	output logic [hcd_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready
);
	import hcd_pkg::*;

	cfg_t       cfg;
	result_t    result;
	result_t    result_s2;
	logic       valid_s1, valid_s2;
	logic [7:0] data_byte_s1;
	logic       body_start_s1;
	logic       advance;

	hcd_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign advance       = valid_s1 && (!valid_s2 || body_out.ready);
	assign body_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body_in.ready) begin
			valid_s1 <= body_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body_in.valid && body_in.ready) begin
			data_byte_s1  <= body_in.data_byte;
			body_start_s1 <= body_in.body_start;
		end
	end

	hcd_parser #(
		.SIZE_BITS(SIZE_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (data_byte_s1),
		.body_start(body_start_s1),
		.cfg       (cfg),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || body_out.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign body_out.valid      = valid_s2;
	assign body_out.byte_out   = result_s2.byte_out;
	assign body_out.byte_kind  = result_s2.byte_kind;
	assign body_out.body_done  = result_s2.body_done;
	assign body_out.error_code = result_s2.error_code;
endmodule
